[src/drbc_pkg.sv]
// ----------------------------------------------------------------------------
// drbc_pkg: shared types and constants of the draw range batch coalescer
// Table entry layout and default sizes.
// ----------------------------------------------------------------------------
package drbc_pkg;

   localparam int MAX_BATCHES_DEF       = 16;
   localparam int DRAW_RECORD_BYTES_DEF = 16;

   localparam logic [15:0] MAX_DRAWS_RST = 16'd4096;
   localparam logic [31:0] MAX_RANGE_RST = 32'd134217472;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_DRAWS = 2'd0;
   localparam logic [1:0] CSR_MAX_RANGE = 2'd1;

   // request commands
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_MERGE = 1'b1;

   typedef struct packed {
      logic [63:0] first;
      logic [63:0] last;
      logic [15:0] size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[src/drbc_ram.sv]
// ----------------------------------------------------------------------------
// drbc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module drbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/draw_range_batch_coalescer_unit.sv]
// ----------------------------------------------------------------------------
// draw_range_batch_coalescer_unit: ordered byte-range batch table
// Adds draws to, or merges incoming batches into, a sorted table of batches,
// inserting a new add batch with an in-place shift, or appending a merged one, when nothing fits.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// req     | in        | req_valid/stall    | command, first_byte, draw_count,
//         |           |                    | last_byte, entry_count
// rsp     | out       | rsp_valid/stall    | batch_index, created, table_full,
//         |           |                    | batch_first, batch_last, batch_entries
// csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
// Sequence: one request at a time. After accept an add passes a span setup
// state; a merge skips it. Each slot visited passes through RAM read, compare
// and, where needed, range check states through the single table RAM port;
// reaching the fill count ends the scan at the read state. An insert reads and
// writes each shifted entry, then writes the new batch; a done state hands the result over.
// Reset: synchronous; clears the table fill count, config to defaults.
// The table RAM itself is not cleared; only slots below the fill count are read.
// A new request is taken once the previous one is parked in the output
// register; a stalled response holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module draw_range_batch_coalescer_unit #(
   parameter int MAX_BATCHES       = drbc_pkg::MAX_BATCHES_DEF,
   parameter int DRAW_RECORD_BYTES = drbc_pkg::DRAW_RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_first_byte,
   input  logic [31:0] req_draw_count,
   input  logic [63:0] req_last_byte,
   input  logic [15:0] req_entry_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_batch_index,
   output logic        rsp_created,
   output logic        rsp_table_full,
   output logic [63:0] rsp_batch_first,
   output logic [63:0] rsp_batch_last,
   output logic [15:0] rsp_batch_entries,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW  = $clog2(MAX_BATCHES);
   localparam int CW  = $clog2(MAX_BATCHES + 1);
   localparam int RBW = $clog2(DRAW_RECORD_BYTES + 1);
   localparam int PW  = 32 + RBW;

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SPAN = 4'd1;  // finish add span end
   localparam logic [3:0] S_RD   = 4'd2;  // issue slot read
   localparam logic [3:0] S_EV   = 4'd3;  // slot data back, compare
   localparam logic [3:0] S_CHK  = 4'd4;  // combined range check
   localparam logic [3:0] S_BRK  = 4'd5;  // scan ended, start insert
   localparam logic [3:0] S_SHRD = 4'd6;  // shift: read slot j-1
   localparam logic [3:0] S_SHWR = 4'd7;  // shift: write slot j
   localparam logic [3:0] S_INS  = 4'd8;  // write new batch
   localparam logic [3:0] S_DONE = 4'd9;  // hand result to output reg

   logic [3:0]  state_ff, state_in;
   logic [15:0] max_draws_ff, max_draws_in;
   logic [31:0] max_range_ff, max_range_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;

   logic        cmd_ff, cmd_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] hi_ff, hi_in;
   logic [15:0] n_ff, n_in;
   logic [PW-1:0] prod_ff, prod_in;

   // per-slot working values
   logic [63:0] emin_ff, emin_in;
   logic [63:0] emax_ff, emax_in;
   logic [15:0] sz_ff, sz_in;
   logic        lo_lt_bs_ff, lo_lt_bs_in;

   // finished result
   logic [3:0]  res_index_ff, res_index_in;
   logic        res_created_ff, res_created_in;
   logic        res_full_ff, res_full_in;
   logic [63:0] res_first_ff, res_first_in;
   logic [63:0] res_last_ff, res_last_in;
   logic [15:0] res_entries_ff, res_entries_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_index_ff;
   logic        rsp_created_ff, rsp_full_ff;
   logic [63:0] rsp_first_ff, rsp_last_ff;
   logic [15:0] rsp_entries_ff;

   // table RAM port
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   drbc_pkg::entry_type  ram_wdata, ram_rdata;

   // compare unit signals
   logic        req_take, out_load;
   logic        slot_full, lo_lt_bs, hi_le_be, covered;
   logic [63:0] diff;
   logic [16:0] merge_sz;
   logic        fits;
   logic [CW-1:0] idx_dec;

   drbc_ram #(
      .WIDTH (drbc_pkg::ENTRY_W),
      .DEPTH (MAX_BATCHES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // slot compares on RAM read data
   assign slot_full = (ram_rdata.size >= max_draws_ff);
   assign lo_lt_bs  = (lo_ff < ram_rdata.first);
   assign hi_le_be  = (hi_ff <= ram_rdata.last);
   assign covered   = !lo_lt_bs && hi_le_be;

   // range check on registered extremes
   assign diff     = emax_ff - emin_ff;
   assign merge_sz = {1'b0, sz_ff} + {1'b0, n_ff};
   assign fits     = (cmd_ff == drbc_pkg::CMD_ADD)
                     ? (diff < {32'd0, max_range_ff})
                     : ((diff <= {32'd0, max_range_ff}) &&
                        (merge_sz <= {1'b0, max_draws_ff}));
   assign idx_dec  = idx_ff - CW'(1);

   always_comb begin
      state_in       = state_ff;
      max_draws_in   = max_draws_ff;
      max_range_in   = max_range_ff;
      used_in        = used_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      cmd_in         = cmd_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      n_in           = n_ff;
      prod_in        = prod_ff;
      emin_in        = emin_ff;
      emax_in        = emax_ff;
      sz_in          = sz_ff;
      lo_lt_bs_in    = lo_lt_bs_ff;
      res_index_in   = res_index_ff;
      res_created_in = res_created_ff;
      res_full_in    = res_full_ff;
      res_first_in   = res_first_ff;
      res_last_in    = res_last_ff;
      res_entries_in = res_entries_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff[AW-1:0];
      ram_raddr      = idx_ff[AW-1:0];
      ram_wdata      = '{first: emin_ff, last: emax_ff, size: sz_ff + 16'd1};

      if (csr_wr_en) begin
         case (csr_index)
            drbc_pkg::CSR_MAX_DRAWS: max_draws_in = csr_wdata[15:0];
            drbc_pkg::CSR_MAX_RANGE: max_range_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in  = req_command;
               lo_in   = req_first_byte;
               hi_in   = req_last_byte;
               n_in    = req_entry_count;
               prod_in = PW'(req_draw_count) * PW'(DRAW_RECORD_BYTES);
               idx_in  = '0;
               state_in = (req_command == drbc_pkg::CMD_ADD) ? S_SPAN : S_RD;
            end
         end
         S_SPAN: begin
            hi_in    = lo_ff + 64'(prod_ff) - 64'd1;
            state_in = S_RD;
         end
         S_RD: begin
            if (idx_ff == used_ff) begin
               state_in = S_BRK;
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            sz_in       = ram_rdata.size;
            lo_lt_bs_in = lo_lt_bs;
            emin_in     = lo_lt_bs ? lo_ff : ram_rdata.first;
            emax_in     = hi_le_be ? ram_rdata.last : hi_ff;
            if (cmd_ff == drbc_pkg::CMD_MERGE) begin
               state_in = S_CHK;
            end else if (slot_full) begin
               if (lo_lt_bs) begin
                  state_in = S_BRK;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end else if (covered) begin
               // draw already inside this batch: count it only
               ram_we         = 1'b1;
               ram_wdata      = '{first: ram_rdata.first, last: ram_rdata.last,
                                  size: ram_rdata.size + 16'd1};
               res_index_in   = 4'(idx_ff);
               res_created_in = 1'b0;
               res_full_in    = 1'b0;
               res_first_in   = ram_rdata.first;
               res_last_in    = ram_rdata.last;
               res_entries_in = ram_rdata.size + 16'd1;
               state_in       = S_DONE;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (fits) begin
               ram_we = 1'b1;
               if (cmd_ff == drbc_pkg::CMD_MERGE) begin
                  ram_wdata.size = merge_sz[15:0];
               end
               res_index_in   = 4'(idx_ff);
               res_created_in = 1'b0;
               res_full_in    = 1'b0;
               res_first_in   = emin_ff;
               res_last_in    = emax_ff;
               res_entries_in = ram_wdata.size;
               state_in       = S_DONE;
            end else if (lo_lt_bs_ff) begin
               state_in = S_BRK;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_BRK: begin
            // merges always append; adds insert where the scan stopped
            pos_in = (cmd_ff == drbc_pkg::CMD_MERGE) ? used_ff : idx_ff;
            idx_in = used_ff;
            if (used_ff == CW'(MAX_BATCHES)) begin
               res_index_in   = 4'd0;
               res_created_in = 1'b0;
               res_full_in    = 1'b1;
               res_first_in   = '0;
               res_last_in    = '0;
               res_entries_in = '0;
               state_in       = S_DONE;
            end else begin
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            ram_raddr = idx_dec[AW-1:0];
            state_in  = (idx_ff == pos_ff) ? S_INS : S_SHWR;
         end
         S_SHWR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_dec;
            state_in  = S_SHRD;
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = '{first: lo_ff, last: hi_ff,
                          size: (cmd_ff == drbc_pkg::CMD_MERGE) ? n_ff : 16'd1};
            used_in        = used_ff + CW'(1);
            res_index_in   = 4'(pos_ff);
            res_created_in = 1'b1;
            res_full_in    = 1'b0;
            res_first_in   = lo_ff;
            res_last_in    = hi_ff;
            res_entries_in = ram_wdata.size;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         max_draws_ff <= drbc_pkg::MAX_DRAWS_RST;
         max_range_ff <= drbc_pkg::MAX_RANGE_RST;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         max_draws_ff <= max_draws_in;
         max_range_ff <= max_range_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      cmd_ff         <= cmd_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      n_ff           <= n_in;
      prod_ff        <= prod_in;
      emin_ff        <= emin_in;
      emax_ff        <= emax_in;
      sz_ff          <= sz_in;
      lo_lt_bs_ff    <= lo_lt_bs_in;
      res_index_ff   <= res_index_in;
      res_created_ff <= res_created_in;
      res_full_ff    <= res_full_in;
      res_first_ff   <= res_first_in;
      res_last_ff    <= res_last_in;
      res_entries_ff <= res_entries_in;
      if (out_load) begin
         rsp_index_ff   <= res_index_ff;
         rsp_created_ff <= res_created_ff;
         rsp_full_ff    <= res_full_ff;
         rsp_first_ff   <= res_first_ff;
         rsp_last_ff    <= res_last_ff;
         rsp_entries_ff <= res_entries_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_batch_index   = rsp_index_ff;
   assign rsp_created       = rsp_created_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_batch_first   = rsp_first_ff;
   assign rsp_batch_last    = rsp_last_ff;
   assign rsp_batch_entries = rsp_entries_ff;

   // fill count never passes the table depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_BATCHES))
      else $error("batch table fill count overflow");

   // a refused insert never reports a new batch
   a_full_no_create: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |-> !rsp_created_ff)
      else $error("table full reported with created batch");

   // the fill count grows only through the insert step
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      used_ff != $past(used_ff) |-> $past(state_ff) == S_INS)
      else $error("fill count changed outside insert");

endmodule
